### hdl/lned_pkg.sv
// Shared types and byte codes for the line editor.
// No dependencies; used by lned_dec, the top level, the checker and the testbench.
`default_nettype none

package lned_pkg;

    // Escape decoder phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ESC  = 3'b010,
        PH_CSI  = 3'b100
    } t_phase;

    // Line status reported with each result beat
    typedef enum logic [2:0] {
        ST_EDIT    = 3'd0,
        ST_SUBMIT  = 3'd1,
        ST_ESCAPED = 3'd2,
        ST_INTR    = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // What one decoded beat asks of the sequencer
    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_LEFT   = 3'd1,
        ACT_RIGHT  = 3'd2,
        ACT_INSERT = 3'd3,
        ACT_DELETE = 3'd4,
        ACT_FINISH = 3'd5
    } t_act;

    typedef struct packed {
        t_act    act;
        t_phase  next_phase;
        t_status status;
    } t_cmd;

    localparam logic [7:0] C_CTRL_C  = 8'd3;
    localparam logic [7:0] C_BS      = 8'd8;
    localparam logic [7:0] C_LF      = 8'd10;
    localparam logic [7:0] C_CR      = 8'd13;
    localparam logic [7:0] C_ESC     = 8'd27;
    localparam logic [7:0] C_DEL     = 8'd127;
    localparam logic [7:0] C_LBRACK  = 8'h5b;
    localparam logic [7:0] C_LEFT    = 8'h44;
    localparam logic [7:0] C_RIGHT   = 8'h43;
    localparam logic [7:0] C_PRINT_LO = 8'h20;
    localparam logic [7:0] C_PRINT_HI = 8'h7e;
    localparam logic [7:0] C_PARAM_HI = 8'h3f;

endpackage

`default_nettype wire

### hdl/lned_mem.sv
// Line byte store: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module lned_mem #(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/lned_dec.sv
// Escape and key decoder: classifies one input beat against the escape phase.
// Depends on lned_pkg.
`default_nettype none

module lned_dec (
    input  wire lned_pkg::t_phase i_phase,
    input  wire logic             i_timeout,
    input  wire logic [7:0]       i_byte,
    output lned_pkg::t_cmd        o_cmd
);

    always_comb begin
        o_cmd.act        = lned_pkg::ACT_NONE;
        o_cmd.next_phase = lned_pkg::PH_IDLE;
        o_cmd.status     = lned_pkg::ST_EDIT;
        case (i_phase)
            lned_pkg::PH_ESC: begin
                if (i_timeout || i_byte != lned_pkg::C_LBRACK) begin
                    o_cmd.act    = lned_pkg::ACT_FINISH;
                    o_cmd.status = lned_pkg::ST_ESCAPED;
                end else begin
                    o_cmd.next_phase = lned_pkg::PH_CSI;
                end
            end
            lned_pkg::PH_CSI: begin
                if (i_timeout) begin
                    o_cmd.act = lned_pkg::ACT_NONE;
                end else if (i_byte inside {[lned_pkg::C_PRINT_LO:lned_pkg::C_PARAM_HI]}) begin
                    o_cmd.next_phase = lned_pkg::PH_CSI;
                end else if (i_byte == lned_pkg::C_LEFT) begin
                    o_cmd.act = lned_pkg::ACT_LEFT;
                end else if (i_byte == lned_pkg::C_RIGHT) begin
                    o_cmd.act = lned_pkg::ACT_RIGHT;
                end
            end
            default: begin
                if (!i_timeout) begin
                    if (i_byte == lned_pkg::C_ESC) begin
                        o_cmd.next_phase = lned_pkg::PH_ESC;
                    end else if (i_byte == lned_pkg::C_CTRL_C) begin
                        o_cmd.act    = lned_pkg::ACT_FINISH;
                        o_cmd.status = lned_pkg::ST_INTR;
                    end else if (i_byte inside {lned_pkg::C_CR, lned_pkg::C_LF}) begin
                        o_cmd.act    = lned_pkg::ACT_FINISH;
                        o_cmd.status = lned_pkg::ST_SUBMIT;
                    end else if (i_byte inside {lned_pkg::C_BS, lned_pkg::C_DEL}) begin
                        o_cmd.act = lned_pkg::ACT_DELETE;
                    end else if (i_byte inside
                                 {[lned_pkg::C_PRINT_LO:lned_pkg::C_PRINT_HI]}) begin
                        o_cmd.act = lned_pkg::ACT_INSERT;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/line_editor_with_escape_decode.sv
// Line editor top level: sequencer, line store and escape decoder.
// Depends on lned_pkg, lned_mem and lned_dec.
//
// Takes one beat at a time (a key byte, or a follow-up timeout) and holds
// o_in_stall high until every result beat it causes has been taken. Editing
// beats (insert, delete, cursor moves, ignored keys) give one result beat;
// an ending (submit, escape, interrupt, full) gives one beat per line byte,
// or a single beat for an empty line, and then clears the line. All byte
// moves go through one shared index stepper and the line store (one write
// port, one registered read port): an insert or delete shifts the k tail
// bytes one place over (one read and one write per byte), and an ending
// reads the n line bytes out one by one, held by any output stall.
// The store has no reset and no clearing pass; only bytes below the current
// length are ever read.
`default_nettype none

module line_editor_with_escape_decode #(
    parameter int MAX_CHARS = 63
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_in_operation,
    input  wire logic [7:0] i_in_byte_value,
    // output channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_out_status,
    output logic [7:0]      o_out_line_byte,
    output logic [6:0]      o_out_line_length,
    output logic [6:0]      o_out_cursor_pos,
    output logic            o_out_last
);

    localparam int CW = $clog2(MAX_CHARS + 1);   // count / cursor width
    localparam int AW = $clog2(MAX_CHARS);       // store address width
    localparam logic [CW-1:0] MAX_C = CW'(MAX_CHARS);
    localparam logic [CW-1:0] ONE   = CW'(1);
    localparam logic [CW-1:0] ZERO  = '0;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,   // waiting for an input beat
        S_EXEC  = 9'b000000010,   // decode and dispatch
        S_SHRD  = 9'b000000100,   // shift: read source byte
        S_SHWR  = 9'b000001000,   // shift: write it one place over
        S_DONE  = 9'b000010000,   // finish insert/delete bookkeeping
        S_RES   = 9'b000100000,   // load the editing result beat
        S_FRD   = 9'b001000000,   // ending: read line byte
        S_FLOAD = 9'b010000000,   // ending: load it into the output reg
        S_OWAIT = 9'b100000000    // result beat on the port
    } t_state;

    t_state r_state, n_state;

    // editor state
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_cursor, n_cursor;
    lned_pkg::t_phase r_phase, n_phase;

    // captured input beat
    logic       r_timeout;
    logic [7:0] r_byte;

    // shared index stepper
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] idx_m1, idx_p1;
    logic          r_ins, n_ins;       // shift direction: insert vs delete
    logic          r_fin, n_fin;       // current run is a line ending
    lned_pkg::t_status r_fstat, n_fstat;

    // output register
    logic [2:0] r_o_status, n_o_status;
    logic [7:0] r_o_byte,   n_o_byte;
    logic [6:0] r_o_len,    n_o_len;
    logic [6:0] r_o_cur,    n_o_cur;
    logic       r_o_last,   n_o_last;

    // store ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    lned_pkg::t_cmd cmd;

    lned_dec u_dec (
        .i_phase   (r_phase),
        .i_timeout (r_timeout),
        .i_byte    (r_byte),
        .o_cmd     (cmd)
    );

    lned_mem #(
        .DEPTH (MAX_CHARS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign idx_m1 = r_idx - ONE;
    assign idx_p1 = r_idx + ONE;

    // Store addressing. Insert moves byte i-1 to i, walking down; delete
    // moves byte i to i-1, walking up. The ending run reads byte r_idx.
    always_comb begin
        mem_raddr = r_ins ? idx_m1[AW-1:0] : r_idx[AW-1:0];
        if (r_state == S_FRD) begin
            mem_raddr = r_idx[AW-1:0];
        end
        mem_we    = 1'b0;
        mem_waddr = r_ins ? r_idx[AW-1:0] : idx_m1[AW-1:0];
        mem_wdata = mem_rdata;
        if (r_state == S_SHWR) begin
            mem_we = 1'b1;
        end else if (r_state == S_DONE && r_ins) begin
            mem_we    = 1'b1;
            mem_waddr = r_cursor[AW-1:0];
            mem_wdata = r_byte;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cursor   = r_cursor;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_ins      = r_ins;
        n_fin      = r_fin;
        n_fstat    = r_fstat;
        n_o_status = r_o_status;
        n_o_byte   = r_o_byte;
        n_o_len    = r_o_len;
        n_o_cur    = r_o_cur;
        n_o_last   = r_o_last;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_phase = cmd.next_phase;
                n_state = S_RES;
                case (cmd.act)
                    lned_pkg::ACT_LEFT: begin
                        if (r_cursor != ZERO) begin
                            n_cursor = r_cursor - ONE;
                        end
                    end
                    lned_pkg::ACT_RIGHT: begin
                        if (r_cursor < r_count) begin
                            n_cursor = r_cursor + ONE;
                        end
                    end
                    lned_pkg::ACT_INSERT: begin
                        n_ins = 1'b1;
                        n_idx = r_count;
                        if (r_count >= MAX_C) begin
                            // full line: drop the byte and end the line
                            n_fin   = 1'b1;
                            n_fstat = lned_pkg::ST_FULL;
                            n_idx   = ZERO;
                            n_state = S_FRD;
                        end else if (r_count > r_cursor) begin
                            n_state = S_SHRD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    lned_pkg::ACT_DELETE: begin
                        n_ins = 1'b0;
                        n_idx = r_cursor;
                        if (r_cursor == ZERO) begin
                            n_state = S_RES;
                        end else if (r_cursor < r_count) begin
                            n_state = S_SHRD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    lned_pkg::ACT_FINISH: begin
                        n_fin   = 1'b1;
                        n_fstat = cmd.status;
                        n_idx   = ZERO;
                        n_state = S_FRD;
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
                // empty line ending: one beat, byte 0
                if (n_fin && r_count == ZERO) begin
                    n_o_status = n_fstat;
                    n_o_byte   = 8'd0;
                    n_o_len    = 7'd0;
                    n_o_cur    = 7'd0;
                    n_o_last   = 1'b1;
                    n_state    = S_OWAIT;
                end
            end

            S_SHRD: begin
                n_state = S_SHWR;
            end

            S_SHWR: begin
                if (r_ins) begin
                    n_idx   = idx_m1;
                    n_state = (idx_m1 > r_cursor) ? S_SHRD : S_DONE;
                end else begin
                    n_idx   = idx_p1;
                    n_state = (idx_p1 < r_count) ? S_SHRD : S_DONE;
                end
            end

            S_DONE: begin
                if (r_ins) begin
                    n_count  = r_count + ONE;
                    n_cursor = r_cursor + ONE;
                end else begin
                    n_count  = r_count - ONE;
                    n_cursor = r_cursor - ONE;
                end
                n_state = S_RES;
            end

            S_RES: begin
                n_o_status = lned_pkg::ST_EDIT;
                n_o_byte   = 8'd0;
                n_o_len    = 7'(r_count);
                n_o_cur    = 7'(r_cursor);
                n_o_last   = 1'b1;
                n_state    = S_OWAIT;
            end

            S_FRD: begin
                n_state = S_FLOAD;
            end

            S_FLOAD: begin
                n_o_status = r_fstat;
                n_o_byte   = mem_rdata;
                n_o_len    = 7'd0;
                n_o_cur    = 7'd0;
                n_o_last   = (idx_p1 == r_count);
                n_state    = S_OWAIT;
            end

            S_OWAIT: begin
                if (!i_out_stall) begin
                    if (!r_o_last) begin
                        n_idx   = idx_p1;
                        n_state = S_FRD;
                    end else begin
                        if (r_fin) begin
                            n_count  = ZERO;
                            n_cursor = ZERO;
                            n_phase  = lned_pkg::PH_IDLE;
                        end
                        n_fin   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= ZERO;
            r_cursor <= ZERO;
            r_phase  <= lned_pkg::PH_IDLE;
            r_fin    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_phase  <= n_phase;
            r_fin    <= n_fin;
        end
    end

    // payload and work registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_timeout <= i_in_operation;
            r_byte    <= i_in_byte_value;
        end
        r_idx      <= n_idx;
        r_ins      <= n_ins;
        r_fstat    <= n_fstat;
        r_o_status <= n_o_status;
        r_o_byte   <= n_o_byte;
        r_o_len    <= n_o_len;
        r_o_cur    <= n_o_cur;
        r_o_last   <= n_o_last;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = (r_state == S_OWAIT);
    assign o_out_status      = r_o_status;
    assign o_out_line_byte   = r_o_byte;
    assign o_out_line_length = r_o_len;
    assign o_out_cursor_pos  = r_o_cur;
    assign o_out_last        = r_o_last;

endmodule

`default_nettype wire

### hdl/lned_chk.sv
// Port-level checker for the line editor, bound to the top level.
// Depends on lned_pkg.
`default_nettype none

module lned_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_in_operation,
    input wire logic [7:0] i_in_byte_value,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_out_status,
    input wire logic [7:0] o_out_line_byte,
    input wire logic [6:0] o_out_line_length,
    input wire logic [6:0] o_out_cursor_pos,
    input wire logic       o_out_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_status)
            && $stable(o_out_line_byte) && $stable(o_out_last))
        else $error("result beat changed while stalled");

    // no new input beat while results are pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    // editing beats are single and carry no line byte
    a_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_status == lned_pkg::ST_EDIT |->
            o_out_last && o_out_line_byte == 8'd0
            && o_out_cursor_pos <= o_out_line_length)
        else $error("malformed editing beat");

    // ending beats report an empty line
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_status != lned_pkg::ST_EDIT |->
            o_out_line_length == 7'd0 && o_out_cursor_pos == 7'd0)
        else $error("ending beat with nonzero length or cursor");

endmodule

bind line_editor_with_escape_decode lned_chk u_lned_chk (.*);

`default_nettype wire

### dv/lned_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the line editor: its own copy of line, cursor and escape phase,
// predicts the result beats of each key beat and checks the DUT against them.
// Depends on lned_pkg.
package lned_tb_pkg;
    import lned_pkg::*;

    localparam int LINE_MAX = 63;

    typedef struct packed {
        t_status    status;
        logic [7:0] line_byte;
        logic [6:0] length;
        logic [6:0] cursor;
        logic       last;
    } t_line_beat;

    class lned_scoreboard;
        logic [7:0]  text [LINE_MAX];
        int unsigned count;
        int unsigned cursor;
        t_phase      phase;
        t_line_beat  due_beats [$];
        int unsigned mismatches;

        function new();
            count      = 0;
            cursor     = 0;
            phase      = PH_IDLE;
            mismatches = 0;
        endfunction

        function int unsigned line_length();
            return count;
        endfunction

        function int unsigned pending();
            return due_beats.size();
        endfunction

        function int unsigned failures();
            return mismatches;
        endfunction

        function void push_beat(t_status st, logic [7:0] b, logic last);
            due_beats.push_back('{st, b, 7'(count), 7'(cursor), last});
        endfunction

        // Ending: one beat per held byte (one zero beat if empty), line cleared first
        function void close_line(t_status st);
            int unsigned n;
            n      = count;
            count  = 0;
            cursor = 0;
            phase  = PH_IDLE;
            if (n == 0) begin
                push_beat(st, 8'h00, 1'b1);
            end else begin
                for (int unsigned k = 0; k < n; k++)
                    push_beat(st, text[k], k == n - 1);
            end
        endfunction

        function void note_key(logic timeout, logic [7:0] key);
            int unsigned i;
            case (phase)
                PH_ESC: begin
                    if (timeout || key != C_LBRACK) begin
                        close_line(ST_ESCAPED);
                        return;
                    end
                    phase = PH_CSI;
                end
                PH_CSI: begin
                    if (timeout) begin
                        phase = PH_IDLE;
                    end else if (!(key >= C_PRINT_LO && key <= C_PARAM_HI)) begin
                        phase = PH_IDLE;
                        if (key == C_LEFT && cursor > 0)
                            cursor--;
                        else if (key == C_RIGHT && cursor < count)
                            cursor++;
                    end
                end
                default: begin
                    if (!timeout) begin
                        if (key == C_ESC) begin
                            phase = PH_ESC;
                        end else if (key == C_CTRL_C) begin
                            close_line(ST_INTR);
                            return;
                        end else if (key == C_CR || key == C_LF) begin
                            close_line(ST_SUBMIT);
                            return;
                        end else if (key == C_BS || key == C_DEL) begin
                            if (cursor > 0) begin
                                for (i = cursor; i < count; i++)
                                    text[i - 1] = text[i];
                                count--;
                                cursor--;
                            end
                        end else if (key >= C_PRINT_LO && key <= C_PRINT_HI) begin
                            if (count >= LINE_MAX) begin
                                close_line(ST_FULL);
                                return;
                            end
                            for (i = count; i > cursor; i--)
                                text[i] = text[i - 1];
                            text[cursor] = key;
                            count++;
                            cursor++;
                        end
                    end
                end
            endcase
            push_beat(ST_EDIT, 8'h00, 1'b1);
        endfunction

        function void check_beat(logic [2:0] st, logic [7:0] b, logic [6:0] len,
                                 logic [6:0] cur, logic last);
            t_line_beat want;
            t_line_beat got;
            got = '{t_status'(st), b, len, cur, last};
            if (due_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: stray beat: st %0d byte %02h len %0d cur %0d last %0d",
                             $time, st, b, len, cur, last);
                return;
            end
            want = due_beats.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: result mismatch (exp/got): status %0d/%0d byte %02h/%02h ",
                           $time, want.status, st, want.line_byte, b);
                    $display("len %0d/%0d cur %0d/%0d last %0d/%0d",
                             want.length, len, want.cursor, cur, want.last, last);
                end
            end
        endfunction
    endclass

endpackage

### dv/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for the line editor: drives key and timeout beats with
// random gaps, stalls the result side at random and checks every result beat.
// Depends on lned_pkg, lned_tb_pkg (lned_scoreboard.sv) and the RTL top level.
module tb;
    import lned_pkg::*;
    import lned_tb_pkg::*;

    localparam logic [8:0] TICK = 9'h100;  // marks a follow-up timeout in the opening list
    localparam int HOLD_CYCLES = 400;      // long receiver hold-off
    localparam int DRAIN_LIMIT = 5000;     // cycles allowed for the last beats to come out
    localparam int TAIL_CYCLES = 200;      // long enough to wait past the worst beat
    localparam int KEY_TARGET  = 330;
    localparam int CALM_FROM   = 290;      // no idling on either side from here on

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_in_operation;
    logic [7:0] i_in_byte_value;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [2:0] o_out_status;
    logic [7:0] o_out_line_byte;
    logic [6:0] o_out_line_length;
    logic [6:0] o_out_cursor_pos;
    logic       o_out_last;

    lned_scoreboard sb;
    int unsigned    keys_sent = 0;
    int unsigned    gap_pct   = 30;
    bit             calm      = 1'b0;
    bit             hold_req  = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    line_editor_with_escape_decode #(
        .MAX_CHARS(LINE_MAX)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_operation   (i_in_operation),
        .i_in_byte_value  (i_in_byte_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_status     (o_out_status),
        .o_out_line_byte  (o_out_line_byte),
        .o_out_line_length(o_out_line_length),
        .o_out_cursor_pos (o_out_cursor_pos),
        .o_out_last       (o_out_last)
    );

    // One input beat. An optional idle burst comes first; valid is only
    // dropped when a gap follows, so back-to-back beats keep it high.
    task automatic send_key(input logic timeout, input logic [7:0] key);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_operation  <= timeout;
        i_in_byte_value <= key;
        // accepted at the first edge with stall low; values read here are pre-edge
        do @(posedge i_clk); while (o_in_stall);
        sb.note_key(timeout, key);
        keys_sent++;
        if (keys_sent >= CALM_FROM)
            calm = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] key);
        send_key(1'b0, key);
    endtask

    // Timeout beat; the byte field is junk and must be ignored by the block
    task automatic send_tick();
        send_key(1'b1, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] any_printable();
        return 8'($urandom_range(C_PRINT_LO, C_PRINT_HI));
    endfunction

    function automatic logic [7:0] any_param();
        return 8'($urandom_range(C_PRINT_LO, C_PARAM_HI));
    endfunction

    // Type the line up to capacity, then either overflow it (status full)
    // or submit it at exactly full length. With a hold-off, the receiver
    // stalls through the long readout while the next beat is waiting.
    task automatic fill_line(input bit with_hold);
        while (sb.line_length() < LINE_MAX)
            send_byte(any_printable());
        if (with_hold) begin
            hold_req = 1'b1;
            send_byte(any_printable());
        end else if ($urandom_range(0, 1) == 0) begin
            send_byte(any_printable());
        end else begin
            send_byte(C_CR);
        end
    endtask

    // Random part: mostly well-formed typing, edits and CSI moves with random
    // content, some endings, broken sequences and raw noise.
    task automatic run_random();
        int unsigned pick;
        int unsigned fills;
        logic [7:0]  key;
        fills = 0;
        while (keys_sent < KEY_TARGET) begin
            // some sequences go without sender gaps at all
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
            pick    = $urandom_range(0, 99);
            if (fills < 2 && keys_sent >= 100 + 80 * fills) begin
                fill_line(fills == 0);
                fills++;
            end else if (pick < 35) begin
                repeat ($urandom_range(1, 8)) send_byte(any_printable());
            end else if (pick < 47) begin
                repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 1) ? C_BS : C_DEL);
            end else if (pick < 62) begin
                // cursor move, left more often so inserts land mid-line
                send_byte(C_ESC);
                send_byte(C_LBRACK);
                repeat ($urandom_range(0, 2)) send_byte(any_param());
                send_byte(($urandom_range(0, 9) < 6) ? C_LEFT : C_RIGHT);
            end else if (pick < 72) begin
                case ($urandom_range(0, 4))
                    0: send_byte(C_CR);
                    1: send_byte(C_LF);
                    2: send_byte(C_CTRL_C);
                    3: begin
                        do key = 8'($urandom_range(0, 255)); while (key == C_LBRACK);
                        send_byte(C_ESC);
                        send_byte(key);
                    end
                    default: begin
                        send_byte(C_ESC);
                        send_tick();
                    end
                endcase
            end else if (pick < 80) begin
                // broken CSI: dropped by timeout or closed by a foreign final
                send_byte(C_ESC);
                send_byte(C_LBRACK);
                repeat ($urandom_range(0, 2)) send_byte(any_param());
                if ($urandom_range(0, 1) == 0) begin
                    send_tick();
                end else begin
                    do key = 8'($urandom_range(0, 255));
                    while (key == C_LEFT || key == C_RIGHT ||
                           (key >= C_PRINT_LO && key <= C_PARAM_HI));
                    send_byte(key);
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 3) == 0)
                        send_tick();
                    else
                        send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // Result monitor: every accepted beat goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_out_status, o_out_line_byte, o_out_line_length,
                          o_out_cursor_pos, o_out_last);
    end

    // Receiver: random stall bursts and ready stretches, one long hold-off
    // on request, no stalls once the run has gone calm.
    initial begin
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #60_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        logic [8:0]  opening [$];
        int unsigned waited;
        sb = new();
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_in_operation  <= 1'b0;
        i_in_byte_value <= 8'h00;

        // Directed opening: idle timeout, empty submit, delete on empty line,
        // printable extremes, CSI left/right with parameter extremes, mid-line
        // insert and deletes, CSI timeout, CR as an ignored CSI final, high
        // and control bytes ignored, LF submit, interrupt on empty line, escape
        // by a non-bracket byte and by a timeout.
        opening = '{TICK, {1'b0, C_CR}, {1'b0, C_BS},
                    {1'b0, C_PRINT_LO}, {1'b0, C_PRINT_HI},
                    {1'b0, C_ESC}, {1'b0, C_LBRACK}, {1'b0, C_LEFT},
                    9'h061, {1'b0, C_BS}, {1'b0, C_DEL},
                    {1'b0, C_ESC}, {1'b0, C_LBRACK}, {1'b0, C_PRINT_LO},
                    {1'b0, C_PARAM_HI}, {1'b0, C_RIGHT},
                    {1'b0, C_ESC}, {1'b0, C_LBRACK}, TICK,
                    {1'b0, C_ESC}, {1'b0, C_LBRACK}, {1'b0, C_CR},
                    9'h080, 9'h001, {1'b0, C_LF}, {1'b0, C_CTRL_C},
                    9'h071, {1'b0, C_ESC}, 9'h078,
                    {1'b0, C_ESC}, TICK};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[j]) begin
            if (opening[j][8])
                send_tick();
            else
                send_byte(opening[j][7:0]);
        end
        run_random();
        i_in_valid <= 1'b0;

        // drain what is still owed, then give a late or stray beat time to show up
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending() != 0) begin
            $display("tb NOT OK");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (sb.failures() == 0 && sb.pending() == 0)
                $display("tb OK");
            else
                $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/lned_pkg.sv
hdl/lned_mem.sv
hdl/lned_dec.sv
hdl/line_editor_with_escape_decode.sv
hdl/lned_chk.sv
dv/lned_scoreboard.sv
dv/tb.sv
